@@ sv/psg_three_voice_sound_generator_defines.svh @@
// Assertion macros for the sound generator RTL.
`ifndef PSG_THREE_VOICE_SOUND_GENERATOR_DEFINES_SVH
`define PSG_THREE_VOICE_SOUND_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PSG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PSG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/psg_pkg.sv @@
// Types, register map and lookup functions of the sound generator.
package psg_pkg;

  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_WRITE_ADDR = 2'd1,
    OP_WRITE_SEL  = 2'd2,
    OP_SELECT     = 2'd3
  } op_t;

  localparam int NUM_VOICES = 3;
  localparam int LEVEL_W    = 9;
  localparam int VOL_W      = 7;

  // Register map
  localparam logic [3:0] REG_TONE_A_FINE    = 4'd0;
  localparam logic [3:0] REG_TONE_A_COARSE  = 4'd1;
  localparam logic [3:0] REG_TONE_B_COARSE  = 4'd3;
  localparam logic [3:0] REG_TONE_C_COARSE  = 4'd5;
  localparam logic [3:0] REG_NOISE_PERIOD   = 4'd6;
  localparam logic [3:0] REG_MIXER          = 4'd7;
  localparam logic [3:0] REG_AMP_A          = 4'd8;
  localparam logic [3:0] REG_AMP_B          = 4'd9;
  localparam logic [3:0] REG_AMP_C          = 4'd10;
  localparam logic [3:0] REG_ENV_FINE       = 4'd11;
  localparam logic [3:0] REG_ENV_COARSE     = 4'd12;
  localparam logic [3:0] REG_ENV_SHAPE      = 4'd13;

  // Envelope shape bits
  localparam int ENV_HOLD = 0;
  localparam int ENV_ALT  = 1;
  localparam int ENV_ATT  = 2;
  localparam int ENV_CONT = 3;

  // Configuration register indexes
  localparam logic CFG_SOUND_CLOCK = 1'b0;
  localparam logic CFG_CPU_CLOCK   = 1'b1;

  localparam int unsigned SOUND_CLOCK_RESET = 1773400;
  localparam int unsigned CPU_CLOCK_RESET   = 3546900;

  localparam logic [16:0] NOISE_SEED = 17'h1ffff;

  typedef logic signed [LEVEL_W-1:0] level_t;

  // State seen by the mixer
  typedef struct packed {
    logic [7:0]                  mixer;
    logic [NUM_VOICES-1:0][4:0]  amp;
    logic [NUM_VOICES-1:0]       tone_level;
    logic                        noise_level;
    logic [3:0]                  env_step;
  } mix_src_t;

  function automatic logic [7:0] reg_mask(input logic [3:0] idx, input logic [7:0] v);
    logic [7:0] m;
    unique case (idx)
      REG_TONE_A_COARSE, REG_TONE_B_COARSE, REG_TONE_C_COARSE, REG_ENV_SHAPE:
        m = v & 8'h0f;
      REG_NOISE_PERIOD, REG_AMP_A, REG_AMP_B, REG_AMP_C:
        m = v & 8'h1f;
      default:
        m = v;
    endcase
    return m;
  endfunction

  // Logarithmic volume table
  function automatic logic [VOL_W-1:0] vol_lookup(input logic [3:0] s);
    logic [VOL_W-1:0] v;
    unique case (s)
      4'd0:  v = 7'd0;
      4'd1:  v = 7'd1;
      4'd2:  v = 7'd1;
      4'd3:  v = 7'd2;
      4'd4:  v = 7'd3;
      4'd5:  v = 7'd4;
      4'd6:  v = 7'd6;
      4'd7:  v = 7'd8;
      4'd8:  v = 7'd11;
      4'd9:  v = 7'd15;
      4'd10: v = 7'd20;
      4'd11: v = 7'd27;
      4'd12: v = 7'd35;
      4'd13: v = 7'd46;
      4'd14: v = 7'd61;
      default: v = 7'd81;
    endcase
    return v;
  endfunction

endpackage

@@ sv/psg_three_voice_sound_generator.sv @@
// Three-voice sound generator top level: beat pipeline, clock divider, mixer.
//
// Input stream (s_axis_*): one beat per item. tuser carries the opcode
// (tick, write addressed register, write selected register, select register),
// tdata carries the register number and the data byte.
// Output stream (m_axis_*): exactly one beat per input beat, in order,
// carrying the signed mixed level of the three voices after that item.
// Config port: cfg_we/cfg_index/cfg_data sets the sound clock (index 0) and
// the CPU clock (index 1); write only while no beat is in flight.
// Path: input register, then state update, then mixer into the output register.
// Throughput: one beat per cycle while m_axis_tready stays high; the register
// file and generators update as a beat leaves the input register, so
// back-to-back ticks flow.
// Stalls: a low m_axis_tready holds the output register; the mixer stage and
// input register still fill, so up to two more beats are taken before
// s_axis_tready drops.
// Reset (rst, synchronous): clears all registers to zero, the noise shifter
// to all ones, the envelope to step 15, and reloads the default clocks.
`include "psg_three_voice_sound_generator_defines.svh"

module psg_three_voice_sound_generator #(
  parameter int CLOCK_WIDTH = 27
) (
  input  logic                   clk,
  input  logic                   rst,
  // config write port
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [CLOCK_WIDTH-1:0] cfg_data,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [15:0]            s_axis_tdata,   // [3:0] reg_index, [11:4] data
  input  logic [1:0]             s_axis_tuser,   // [1:0] opcode
  // output stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [15:0]            m_axis_tdata    // [8:0] level
);

  // input register
  logic              in_valid;
  psg_pkg::op_t      in_op;
  logic [3:0]        in_idx;
  logic [7:0]        in_data;

  // mixer stage: state already updated, level pending
  logic              mix_valid;
  psg_pkg::level_t   mix_level;

  // output register
  logic              out_valid;
  psg_pkg::level_t   out_level;

  logic              s_accept;
  logic              proc_fire;
  logic              out_load;
  logic              gen_tick;
  logic              sound_on;
  psg_pkg::mix_src_t mix_src;

  assign out_load      = mix_valid && (!out_valid || m_axis_tready);
  assign proc_fire     = in_valid && (!mix_valid || out_load);
  assign s_axis_tready = !in_valid || proc_fire;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      mix_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_accept) begin
        in_valid <= 1'b1;
      end else if (proc_fire) begin
        in_valid <= 1'b0;
      end
      if (proc_fire) begin
        mix_valid <= 1'b1;
      end else if (out_load) begin
        mix_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_op   <= psg_pkg::op_t'(s_axis_tuser);
      in_idx  <= s_axis_tdata[3:0];
      in_data <= s_axis_tdata[11:4];
    end
    if (out_load) begin
      out_level <= mix_level;
    end
  end

  psg_clkdiv #(
    .CLOCK_WIDTH (CLOCK_WIDTH)
  ) u_clkdiv (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick_req  (proc_fire && in_op == psg_pkg::OP_TICK),
    .gen_tick  (gen_tick),
    .sound_on  (sound_on)
  );

  psg_gen u_gen (
    .clk        (clk),
    .rst        (rst),
    .item_valid (proc_fire),
    .op         (in_op),
    .reg_index  (in_idx),
    .data       (in_data),
    .gen_tick   (gen_tick),
    .mix_src    (mix_src)
  );

  // mixer reads the state left by the last processed item
  psg_mix u_mix (
    .mix_src  (mix_src),
    .sound_on (sound_on),
    .level    (mix_level)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'b0000000, out_level};

  // accepted beat lands in the input register
  `PSG_ASSERT_NEXT(a_in_capture, clk, rst, s_accept, in_valid,
    "accepted beat not held in input register")
  // a pending level must not move while the output is blocked
  `PSG_ASSERT_NEXT(a_mix_hold, clk, rst, mix_valid && !out_load,
    mix_valid && $stable(mix_level), "pending level changed while stalled")
  // silence while the sound clock is zero
  `PSG_ASSERT_NEXT(a_silence, clk, rst, out_load && !sound_on, out_level == '0,
    "nonzero level with sound clock off")

endmodule

@@ sv/psg_clkdiv.sv @@
// Clock configuration and fractional accumulator that issues generator ticks.
module psg_clkdiv #(
  parameter int CLOCK_WIDTH = 27
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [CLOCK_WIDTH-1:0] cfg_data,
  input  logic                   tick_req,
  output logic                   gen_tick,
  output logic                   sound_on
);

  localparam logic [CLOCK_WIDTH-1:0] ONE       = CLOCK_WIDTH'(1);
  localparam logic [CLOCK_WIDTH-1:0] SOUND_RST = CLOCK_WIDTH'(psg_pkg::SOUND_CLOCK_RESET);
  localparam logic [CLOCK_WIDTH-1:0] CPU_RST   = CLOCK_WIDTH'(psg_pkg::CPU_CLOCK_RESET);
  localparam logic [CLOCK_WIDTH-1:0] CPU_EFF_RST = (CPU_RST == '0) ? ONE : CPU_RST;
  localparam logic [CLOCK_WIDTH-1:0] S_EFF_RST =
    (SOUND_RST < CPU_EFF_RST) ? SOUND_RST : CPU_EFF_RST;
  localparam logic [CLOCK_WIDTH:0] DIFF_RST = {1'b0, S_EFF_RST} - {1'b0, CPU_EFF_RST};

  logic [CLOCK_WIDTH-1:0] sound_hz;
  logic [CLOCK_WIDTH-1:0] cpu_hz;
  logic [CLOCK_WIDTH-1:0] cpu_eff;     // cpu clock, zero read as one
  logic [CLOCK_WIDTH-1:0] s_eff;       // sound clock saturated at cpu clock
  logic [CLOCK_WIDTH:0]   s_minus_cpu; // s_eff - cpu_eff, never positive
  logic [CLOCK_WIDTH-1:0] accum;

  logic [CLOCK_WIDTH-1:0] sound_cand, cpu_cand;
  logic [CLOCK_WIDTH-1:0] cpu_eff_next, s_eff_next;
  logic [CLOCK_WIDTH:0]   s_minus_cpu_next;
  logic [CLOCK_WIDTH-1:0] accum_next;
  logic [CLOCK_WIDTH-1:0] sum;
  logic [CLOCK_WIDTH:0]   diff;
  logic                   clamp;
  logic                   wrap;

  // derived values recomputed on a config write
  always_comb begin
    sound_cand = (cfg_we && cfg_index == psg_pkg::CFG_SOUND_CLOCK) ? cfg_data : sound_hz;
    cpu_cand   = (cfg_we && cfg_index == psg_pkg::CFG_CPU_CLOCK) ? cfg_data : cpu_hz;
    cpu_eff_next = (cpu_cand == '0) ? ONE : cpu_cand;
    s_eff_next   = (sound_cand < cpu_eff_next) ? sound_cand : cpu_eff_next;
    s_minus_cpu_next = {1'b0, s_eff_next} - {1'b0, cpu_eff_next};
  end

  // accumulator: clamp case always ticks since s_eff >= 1
  always_comb begin
    sound_on = (sound_hz != '0);
    clamp    = (accum >= cpu_eff);
    sum      = accum + s_eff;
    diff     = {1'b0, accum} + s_minus_cpu;
    wrap     = clamp || !diff[CLOCK_WIDTH];
    gen_tick = tick_req && sound_on && wrap;
    if (clamp) begin
      accum_next = s_eff - ONE;
    end else if (!diff[CLOCK_WIDTH]) begin
      accum_next = diff[CLOCK_WIDTH-1:0];
    end else begin
      accum_next = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sound_hz    <= SOUND_RST;
      cpu_hz      <= CPU_RST;
      cpu_eff     <= CPU_EFF_RST;
      s_eff       <= S_EFF_RST;
      s_minus_cpu <= DIFF_RST;
      accum       <= '0;
    end else begin
      if (cfg_we) begin
        sound_hz    <= sound_cand;
        cpu_hz      <= cpu_cand;
        cpu_eff     <= cpu_eff_next;
        s_eff       <= s_eff_next;
        s_minus_cpu <= s_minus_cpu_next;
      end
      if (tick_req && sound_on) begin
        accum <= accum_next;
      end
    end
  end

endmodule

@@ sv/psg_gen.sv @@
// Register file, tone, noise and envelope generators.
module psg_gen (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  psg_pkg::op_t       op,
  input  logic [3:0]         reg_index,
  input  logic [7:0]         data,
  input  logic               gen_tick,
  output psg_pkg::mix_src_t  mix_src
);

  logic [7:0]  regs [16];
  logic [3:0]  selected_reg;
  logic [15:0] tone_count [psg_pkg::NUM_VOICES];
  logic [psg_pkg::NUM_VOICES-1:0] tone_level;
  logic [7:0]  noise_count;
  logic [16:0] noise_shift;
  logic        noise_level;
  logic [19:0] env_count;
  logic [3:0]  env_step;
  logic        env_holding;
  logic        env_rising;

  logic [3:0]  widx;
  logic [7:0]  wval;
  logic        do_write;
  logic        env_restart;

  logic [15:0] tone_count_next [psg_pkg::NUM_VOICES];
  logic [psg_pkg::NUM_VOICES-1:0] tone_level_next;
  logic [7:0]  noise_count_next;
  logic [16:0] noise_shift_next;
  logic        noise_level_next;
  logic [19:0] env_count_next;
  logic [3:0]  env_step_next;
  logic        env_holding_next;
  logic        env_rising_next;

  // register write path
  always_comb begin
    widx = (op == psg_pkg::OP_WRITE_ADDR) ? reg_index : selected_reg;
    wval = psg_pkg::reg_mask(widx, data);
    do_write = item_valid && (op == psg_pkg::OP_WRITE_ADDR || op == psg_pkg::OP_WRITE_SEL);
    env_restart = do_write && (regs[widx] != wval) && (widx == psg_pkg::REG_ENV_SHAPE);
  end

  // tone channels
  always_comb begin
    logic [11:0] period;
    logic [14:0] half;
    logic [16:0] inc;
    for (int ch = 0; ch < psg_pkg::NUM_VOICES; ch++) begin
      period = {regs[4'(2 * ch + 1)][3:0], regs[4'(2 * ch)]};
      if (period == '0) period = 12'd1;
      half = {period, 3'b000};
      inc  = {1'b0, tone_count[ch]} + 17'd1;
      if (inc >= {2'b00, half}) begin
        tone_count_next[ch] = '0;
        tone_level_next[ch] = ~tone_level[ch];
      end else begin
        tone_count_next[ch] = inc[15:0];
        tone_level_next[ch] = tone_level[ch];
      end
    end
  end

  // noise
  always_comb begin
    logic [4:0] period;
    logic [7:0] half;
    logic [8:0] inc;
    period = regs[psg_pkg::REG_NOISE_PERIOD][4:0];
    if (period == '0) period = 5'd1;
    half = {period, 3'b000};
    inc  = {1'b0, noise_count} + 9'd1;
    noise_shift_next = noise_shift;
    noise_level_next = noise_level;
    if (inc >= {1'b0, half}) begin
      noise_count_next = '0;
      noise_shift_next = {noise_shift[0] ^ noise_shift[3], noise_shift[16:1]};
      noise_level_next = noise_shift_next[0];
    end else begin
      noise_count_next = inc[7:0];
    end
  end

  // envelope step on a generator tick
  always_comb begin
    logic [15:0] period;
    logic [19:0] eper;
    logic [20:0] inc;
    logic [3:0]  shape;
    logic        rise_t;
    period = {regs[psg_pkg::REG_ENV_COARSE], regs[psg_pkg::REG_ENV_FINE]};
    if (period == '0) period = 16'd1;
    eper  = {period, 4'b0000};
    inc   = {1'b0, env_count} + 21'd1;
    shape = regs[psg_pkg::REG_ENV_SHAPE][3:0];
    rise_t = ~env_rising;
    env_count_next   = env_count;
    env_step_next    = env_step;
    env_holding_next = env_holding;
    env_rising_next  = env_rising;
    if (!env_holding) begin
      if (inc < {1'b0, eper}) begin
        env_count_next = inc[19:0];
      end else begin
        env_count_next = '0;
        priority if (env_rising && env_step != 4'd15) begin
          env_step_next = env_step + 4'd1;
        end else if (!env_rising && env_step != 4'd0) begin
          env_step_next = env_step - 4'd1;
        end else if (!shape[psg_pkg::ENV_CONT]) begin
          env_step_next    = 4'd0;
          env_holding_next = 1'b1;
          env_rising_next  = 1'b0;
        end else if (shape[psg_pkg::ENV_HOLD]) begin
          // hold at the far end when alternating
          if (shape[psg_pkg::ENV_ALT]) begin
            env_rising_next = rise_t;
            env_step_next   = ~env_step;
          end
          env_holding_next = 1'b1;
        end else begin
          if (shape[psg_pkg::ENV_ALT]) begin
            env_rising_next = rise_t;
            env_step_next   = rise_t ? 4'd0 : 4'd15;
          end else begin
            env_step_next   = env_rising ? 4'd0 : 4'd15;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs         <= '{default: '0};
      selected_reg <= '0;
      tone_count   <= '{default: '0};
      tone_level   <= '0;
      noise_count  <= '0;
      noise_shift  <= psg_pkg::NOISE_SEED;
      noise_level  <= 1'b1;
      env_count    <= '0;
      env_step     <= 4'd15;
      env_holding  <= 1'b0;
      env_rising   <= 1'b0;
    end else begin
      if (item_valid && op == psg_pkg::OP_SELECT) begin
        selected_reg <= reg_index;
      end
      if (do_write) begin
        regs[widx] <= wval;
      end
      if (gen_tick) begin
        tone_count  <= tone_count_next;
        tone_level  <= tone_level_next;
        noise_count <= noise_count_next;
        noise_shift <= noise_shift_next;
        noise_level <= noise_level_next;
      end
      if (env_restart) begin
        env_count   <= '0;
        env_holding <= 1'b0;
        env_rising  <= wval[psg_pkg::ENV_ATT];
        env_step    <= wval[psg_pkg::ENV_ATT] ? 4'd0 : 4'd15;
      end else if (gen_tick) begin
        env_count   <= env_count_next;
        env_step    <= env_step_next;
        env_holding <= env_holding_next;
        env_rising  <= env_rising_next;
      end
    end
  end

  always_comb begin
    mix_src.mixer       = regs[psg_pkg::REG_MIXER];
    mix_src.amp[0]      = regs[psg_pkg::REG_AMP_A][4:0];
    mix_src.amp[1]      = regs[psg_pkg::REG_AMP_B][4:0];
    mix_src.amp[2]      = regs[psg_pkg::REG_AMP_C][4:0];
    mix_src.tone_level  = tone_level;
    mix_src.noise_level = noise_level;
    mix_src.env_step    = env_step;
  end

endmodule

@@ sv/psg_mix.sv @@
// Mixer: gates tone and noise per voice and sums the signed volumes.
module psg_mix (
  input  psg_pkg::mix_src_t  mix_src,
  input  logic               sound_on,
  output psg_pkg::level_t    level
);

  always_comb begin
    psg_pkg::level_t            acc;
    logic [psg_pkg::VOL_W-1:0]  vol;
    logic                       t;
    logic                       n;
    acc = '0;
    for (int ch = 0; ch < psg_pkg::NUM_VOICES; ch++) begin
      t = mix_src.mixer[ch] | mix_src.tone_level[ch];
      n = mix_src.mixer[ch + 3] | mix_src.noise_level;
      vol = mix_src.amp[ch][4] ? psg_pkg::vol_lookup(mix_src.env_step)
                               : psg_pkg::vol_lookup(mix_src.amp[ch][3:0]);
      if (t && n) begin
        acc = acc + $signed({2'b00, vol});
      end else begin
        acc = acc - $signed({2'b00, vol});
      end
    end
    level = sound_on ? acc : '0;
  end

endmodule

@@ tb/psg_level_scoreboard_pkg.sv @@
// Scoreboard class for the sound generator: level predictor and result checks.
`timescale 1ns / 1ps

package psg_level_scoreboard_pkg;
  import psg_pkg::*;

  localparam int CW = 27;

  class level_scoreboard;
    // clock setup
    logic [CW-1:0] sound_hz;
    logic [CW-1:0] cpu_hz;
    // chip state
    logic [7:0]    regs [16];
    logic [3:0]    sel;
    logic [CW-1:0] accum;
    logic [15:0]   tone_cnt [NUM_VOICES];
    logic          tone_lvl [NUM_VOICES];
    logic [7:0]    noise_cnt;
    logic [16:0]   noise_sr;
    logic          noise_lvl;
    logic [19:0]   env_cnt;
    logic [3:0]    env_step;
    logic          env_hold;
    logic          env_up;
    int            vol_tab [16];
    // levels owed by the block, oldest first
    level_t        level_q [$];
    int            errors;
    int            checked;
    int            n_items;
    int            n_ticks;
    int            n_gen_ticks;
    int            n_restarts;

    function new();
      vol_tab = '{0, 1, 1, 2, 3, 4, 6, 8, 11, 15, 20, 27, 35, 46, 61, 81};
      errors = 0;
      checked = 0;
      n_items = 0;
      n_ticks = 0;
      n_gen_ticks = 0;
      n_restarts = 0;
      reset_state();
    endfunction

    function void reset_state();
      sound_hz = CW'(SOUND_CLOCK_RESET);
      cpu_hz = CW'(CPU_CLOCK_RESET);
      foreach (regs[i]) regs[i] = 8'h00;
      sel = 4'd0;
      accum = '0;
      foreach (tone_cnt[i]) begin
        tone_cnt[i] = 16'd0;
        tone_lvl[i] = 1'b0;
      end
      noise_cnt = 8'd0;
      noise_sr = NOISE_SEED;
      noise_lvl = 1'b1;
      restart_env();
    endfunction

    function void set_clock(logic idx, logic [CW-1:0] v);
      if (idx == CFG_SOUND_CLOCK) sound_hz = v;
      else cpu_hz = v;
    endfunction

    function void restart_env();
      env_cnt = 20'd0;
      env_hold = 1'b0;
      env_up = regs[REG_ENV_SHAPE][ENV_ATT];
      env_step = env_up ? 4'd0 : 4'd15;
    endfunction

    function void write_reg(logic [3:0] idx, logic [7:0] v);
      logic [7:0] m;
      case (idx)
        REG_TONE_A_COARSE, REG_TONE_B_COARSE, REG_TONE_C_COARSE, REG_ENV_SHAPE: m = v & 8'h0f;
        REG_NOISE_PERIOD, REG_AMP_A, REG_AMP_B, REG_AMP_C: m = v & 8'h1f;
        default: m = v;
      endcase
      if (regs[idx] == m) return;
      regs[idx] = m;
      if (idx == REG_ENV_SHAPE) begin
        n_restarts++;
        restart_env();
      end
    endfunction

    function void env_tick();
      int unsigned period;
      logic [3:0]  shape;
      if (env_hold) return;
      period = {regs[REG_ENV_COARSE], regs[REG_ENV_FINE]};
      if (period == 0) period = 1;
      period = period * 16;
      env_cnt++;
      if (env_cnt < period) return;
      env_cnt = 20'd0;
      if (env_up && env_step < 4'd15) begin
        env_step++;
        return;
      end
      if (!env_up && env_step > 4'd0) begin
        env_step--;
        return;
      end
      shape = regs[REG_ENV_SHAPE][3:0];
      // one-shot shapes drop to silence and stay there
      if (!shape[ENV_CONT]) begin
        env_step = 4'd0;
        env_hold = 1'b1;
        env_up = 1'b0;
        return;
      end
      if (shape[ENV_HOLD]) begin
        // hold with alternate ends on the opposite extreme
        if (shape[ENV_ALT]) begin
          env_up = !env_up;
          env_step = 4'd15 - env_step;
        end
        env_hold = 1'b1;
        return;
      end
      if (shape[ENV_ALT]) env_up = !env_up;
      env_step = env_up ? 4'd0 : 4'd15;
    endfunction

    function void gen_tick();
      int unsigned half;
      logic        fb;
      n_gen_ticks++;
      for (int ch = 0; ch < NUM_VOICES; ch++) begin
        half = {regs[2*ch+1][3:0], regs[2*ch]};
        if (half == 0) half = 1;
        half = half * 8;
        tone_cnt[ch]++;
        if (tone_cnt[ch] >= half) begin
          tone_cnt[ch] = 16'd0;
          tone_lvl[ch] = !tone_lvl[ch];
        end
      end
      half = regs[REG_NOISE_PERIOD][4:0];
      if (half == 0) half = 1;
      half = half * 8;
      noise_cnt++;
      if (noise_cnt >= half) begin
        noise_cnt = 8'd0;
        fb = noise_sr[0] ^ noise_sr[3];
        noise_sr = {fb, noise_sr[16:1]};
        noise_lvl = noise_sr[0];
      end
      env_tick();
    endfunction

    function level_t mix_level();
      int         lvl;
      int         vol;
      logic       t;
      logic       n;
      logic [4:0] amp;
      if (sound_hz == 0) return level_t'(0);
      lvl = 0;
      for (int ch = 0; ch < NUM_VOICES; ch++) begin
        // a set mixer bit gates its source off, which reads as high
        t = regs[REG_MIXER][ch] | tone_lvl[ch];
        n = regs[REG_MIXER][3+ch] | noise_lvl;
        amp = regs[REG_AMP_A + ch][4:0];
        vol = amp[4] ? vol_tab[env_step] : vol_tab[amp[3:0]];
        lvl += (t && n) ? vol : -vol;
      end
      return level_t'(lvl);
    endfunction

    // Called for each input beat the block takes.
    function void note_item(op_t op, logic [3:0] idx, logic [7:0] dat);
      longint unsigned cpu;
      longint unsigned snd;
      longint unsigned acc;
      n_items++;
      case (op)
        OP_TICK: begin
          n_ticks++;
          if (sound_hz != 0) begin
            cpu = (cpu_hz == 0) ? 1 : cpu_hz;
            snd = (sound_hz < cpu) ? sound_hz : cpu;
            if (accum >= cpu) accum = CW'(cpu - 1);
            acc = accum + snd;
            if (acc >= cpu) begin
              acc -= cpu;
              gen_tick();
            end
            accum = CW'(acc);
          end
        end
        OP_WRITE_ADDR: write_reg(idx, dat);
        OP_WRITE_SEL:  write_reg(sel, dat);
        default:       sel = idx;
      endcase
      level_q.push_back(mix_level());
    endfunction

    // Called for each output beat the block hands over.
    task check_level(level_t got);
      level_t want;
      if (level_q.size() == 0) begin
        report($sformatf("level %0d arrived with nothing expected", got));
        return;
      end
      want = level_q.pop_front();
      checked++;
      if (got !== want)
        report($sformatf("result %0d: level %0d, expected %0d", checked, got, want));
    endtask

    task report(string msg);
      errors++;
      $display("ERROR: %s", msg);
    endtask

    function int pending();
      return level_q.size();
    endfunction
  endclass

endpackage

@@ tb/testbench.sv @@
// Stream testbench for the three-voice sound generator: stimulus, stalls, checks.
`timescale 1ns / 1ps

module testbench;
  import psg_pkg::*;
  import psg_level_scoreboard_pkg::*;

  // registers the package leaves unnamed
  localparam logic [3:0] REG_TONE_B_FINE = 4'd2;
  localparam logic [3:0] REG_TONE_C_FINE = 4'd4;
  localparam logic [3:0] REG_PORT_A      = 4'd14;
  localparam logic [3:0] REG_PORT_B      = 4'd15;

  // receiver hold-off: length and the result counts that trigger it
  localparam int HOLD_OFF_CYCLES = 64;
  localparam int HOLD_AT_FIRST   = 300;
  localparam int HOLD_AT_SECOND  = 800;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic          cfg_index = 1'b0;
  logic [CW-1:0] cfg_data = '0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [15:0]   s_axis_tdata = '0;   // [3:0] reg_index, [11:4] data
  logic [1:0]    s_axis_tuser = '0;   // [1:0] opcode
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [15:0]   m_axis_tdata;        // [8:0] level

  level_scoreboard sb;

  bit calm = 1'b0;           // set for the closing phase: no idling on either side
  bit follow_select = 1'b0;  // next beat writes the register just selected
  int long_left = 0;
  int gap_left = 0;
  int n_settings = 0;

  psg_three_voice_sound_generator #(
    .CLOCK_WIDTH(CW)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #2 clk = ~clk;

  // Receiver. Values read at the edge are the ones from before it, so the
  // handshake seen here is exactly the one the block saw.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_level(level_t'(m_axis_tdata[8:0]));
        // long hold-off: the block fills up and must drop s_axis_tready
        if (sb.checked == HOLD_AT_FIRST || sb.checked == HOLD_AT_SECOND)
          long_left = HOLD_OFF_CYCLES;
      end
      if (!calm && long_left == 0 && gap_left == 0 && $urandom_range(0, 7) == 0)
        gap_left = $urandom_range(1, 5);
      if (long_left > 0) begin
        long_left--;
        m_axis_tready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // One beat: hold it until the block takes it, then book the expected level.
  // Leaves tvalid high so a following beat goes out back to back.
  task automatic send_beat(input op_t op, input logic [3:0] idx, input logic [7:0] dat);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {4'b0000, dat, idx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_item(op, idx, dat);
  endtask

  task automatic idle_source(input int cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Both clocks go in on consecutive edges; we stays high across the pair.
  task automatic set_clocks(input logic [CW-1:0] snd, input logic [CW-1:0] cpu);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SOUND_CLOCK;
    cfg_data <= snd;
    @(posedge clk);
    cfg_index <= CFG_CPU_CLOCK;
    cfg_data <= cpu;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_clock(CFG_SOUND_CLOCK, snd);
    sb.set_clock(CFG_CPU_CLOCK, cpu);
    n_settings++;
  endtask

  // Wait for every owed level, then let the block settle.
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register data biased toward short periods so tones, noise and the
  // envelope all run through many cycles within a few hundred ticks.
  function automatic logic [7:0] shaped_byte(input logic [3:0] idx);
    logic [7:0] v;
    v = 8'($urandom);
    case (idx)
      REG_TONE_A_FINE, REG_TONE_B_FINE, REG_TONE_C_FINE: v = 8'($urandom_range(0, 6));
      REG_TONE_A_COARSE, REG_TONE_B_COARSE, REG_TONE_C_COARSE: v = 8'h00;
      REG_NOISE_PERIOD: v = 8'($urandom_range(0, 3));
      REG_AMP_A, REG_AMP_B, REG_AMP_C: v = 8'($urandom_range(0, 31));
      REG_ENV_FINE: v = 8'($urandom_range(0, 2));
      REG_ENV_COARSE: v = 8'h00;
      REG_ENV_SHAPE: v = 8'($urandom_range(0, 15));
      default: ;
    endcase
    return v;
  endfunction

  // Mostly ticks; selects are usually followed by a write to that register.
  function automatic void pick_item(output op_t op, output logic [3:0] idx,
                                    output logic [7:0] dat);
    int r;
    r = $urandom_range(0, 99);
    idx = 4'($urandom);
    dat = 8'($urandom);
    if (follow_select) begin
      op = OP_WRITE_SEL;
      follow_select = 1'b0;
    end else if (r < 70) begin
      op = OP_TICK;
    end else if (r < 86) begin
      op = OP_WRITE_ADDR;
    end else if (r < 93) begin
      op = OP_SELECT;
    end else begin
      op = OP_WRITE_SEL;
    end
    if (op == OP_SELECT) follow_select = ($urandom_range(0, 9) < 7);
    // one write in five keeps full random data to exercise the masks
    if (op == OP_WRITE_ADDR && $urandom_range(0, 4) != 0) dat = shaped_byte(idx);
    if (op == OP_WRITE_SEL && $urandom_range(0, 4) != 0) dat = shaped_byte(sb.sel);
  endfunction

  task automatic run_phase(input logic [CW-1:0] snd, input logic [CW-1:0] cpu,
                           input int count);
    op_t        op;
    logic [3:0] idx;
    logic [7:0] dat;
    drain();
    set_clocks(snd, cpu);
    for (int i = 0; i < count; i++) begin
      pick_item(op, idx, dat);
      if (!calm && $urandom_range(0, 5) == 0) idle_source($urandom_range(1, 5));
      send_beat(op, idx, dat);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed beats at the power-up clocks (sound clock just under half the CPU clock).
    send_beat(OP_WRITE_ADDR, REG_MIXER, 8'h00);          // same value as reset
    send_beat(OP_WRITE_ADDR, REG_AMP_A, 8'hff);          // masked to envelope mode
    send_beat(OP_WRITE_ADDR, REG_AMP_B, 8'h0f);          // loudest fixed volume
    send_beat(OP_WRITE_ADDR, REG_AMP_C, 8'h10);
    send_beat(OP_WRITE_ADDR, REG_TONE_A_COARSE, 8'hff);  // keeps 4 bits
    send_beat(OP_WRITE_ADDR, REG_TONE_A_FINE, 8'hff);
    send_beat(OP_WRITE_ADDR, REG_NOISE_PERIOD, 8'hff);   // keeps 5 bits
    send_beat(OP_WRITE_ADDR, REG_ENV_SHAPE, 8'hfe);      // restart, attack
    send_beat(OP_WRITE_ADDR, REG_ENV_SHAPE, 8'h0e);      // equal value: no restart
    send_beat(OP_TICK, 4'hf, 8'hff);
    send_beat(OP_TICK, 4'h0, 8'h00);
    send_beat(OP_WRITE_ADDR, REG_PORT_A, 8'ha5);         // stored, no effect
    send_beat(OP_SELECT, REG_PORT_B, 8'h00);
    send_beat(OP_WRITE_SEL, 4'h0, 8'h5a);
    send_beat(OP_SELECT, REG_ENV_SHAPE, 8'hff);
    send_beat(OP_WRITE_SEL, 4'hf, 8'h0b);                // hold with alternate
    send_beat(OP_WRITE_ADDR, REG_TONE_A_COARSE, 8'h00);
    send_beat(OP_WRITE_ADDR, REG_TONE_A_FINE, 8'h00);    // zero tone period
    send_beat(OP_WRITE_ADDR, REG_NOISE_PERIOD, 8'h00);   // zero noise period
    send_beat(OP_WRITE_ADDR, REG_ENV_COARSE, 8'hff);
    send_beat(OP_WRITE_ADDR, REG_ENV_COARSE, 8'h00);     // zero envelope period
    send_beat(OP_TICK, 4'h5, 8'h3c);
    send_beat(OP_TICK, 4'ha, 8'hc3);
    send_beat(OP_WRITE_ADDR, REG_MIXER, 8'hff);          // all sources gated off
    send_beat(OP_TICK, 4'h0, 8'h00);
    s_axis_tvalid <= 1'b0;

    // Random phases, clocks changed only with nothing in flight.
    run_phase(27'd1000, 27'd1000, 450);                  // generator tick every tick
    run_phase(27'd0, 27'd5, 100);                        // sound clock off: silence
    run_phase(27'd7, 27'd0, 200);                        // CPU clock 0 acts as 1
    run_phase(27'd100_000_000, 27'd1, 150);              // sound clock saturates
    run_phase(27'd99_999_999, 27'd100_000_000, 60);      // drives the accumulator high
    run_phase(27'd300, 27'd1000, 150);                   // accumulator above new CPU clock
    run_phase(27'd3, 27'd7, 150);
    run_phase(27'h7ff_ffff, 27'h7ff_ffff, 100);
    run_phase(CW'($urandom), CW'($urandom), 100);
    calm = 1'b1;
    run_phase(27'd1, 27'd1, 200);

    drain();
    repeat (8) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected levels never arrived", sb.pending()));

    $display("Run covered %0d beats (%0d ticks, %0d generator ticks) under %0d clock setups;",
             sb.n_items, sb.n_ticks, sb.n_gen_ticks, n_settings + 1);
    $display("%0d levels compared, %0d envelope restarts, %0d mismatches.",
             sb.checked, sb.n_restarts, sb.errors);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Timeout with %0d levels still owed", sb.pending());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
